/* rtl/tcw_pkg.sv */
// shared constants and types for the text console character writer
package tcw_pkg;

  localparam int CHAR_W = 8;
  localparam int ATTR_W = 8;
  localparam int IDX_W  = 11;
  localparam int POS_W  = 11;

  localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
  localparam logic [CHAR_W-1:0] CH_BLANK     = 8'd0;

  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  localparam logic KIND_PUT  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic              step;
    logic [CHAR_W-1:0] ch;
  } cur_cmd_t;

  typedef struct packed {
    logic              we;
    logic [CHAR_W-1:0] wchar;
    logic              scroll;
  } cur_wr_t;

endpackage

/* rtl/tcw_ifs.sv */
// valid/ready channel interfaces for input and result words
interface tcw_in_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic              kind;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, kind, char_code, cell_index, input ready);
  modport sink   (input valid, kind, char_code, cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*;;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  cursor_position;
  logic [CHAR_W-1:0] cell_char;
  logic [ATTR_W-1:0] cell_attr;

  modport source (output valid, cursor_position, cell_char, cell_attr, input ready);
  modport sink   (input valid, cursor_position, cell_char, cell_attr, output ready);
endinterface

/* rtl/tcw_cursor.sv */
// cursor column, row and linear position with teletype stepping rules
module tcw_cursor import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  cur_cmd_t                                cmd_i,
  output cur_wr_t                                 wr_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]         waddr_o,
  output logic [$clog2(COLUMNS*ROWS)-1:0]         lin_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LW    = $clog2(CELLS);
  localparam int CW    = $clog2(COLUMNS);
  localparam int RW    = $clog2(ROWS);
  localparam logic [LW-1:0] LIN_BOTTOM = LW'((ROWS - 1) * COLUMNS);

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;
  logic [LW-1:0] lin_q, lin_d;
  logic          wrap;
  logic          home;

  assign home = (col_q == '0) && (row_q == '0);

  always_comb begin
    col_d     = col_q;
    row_d     = row_q;
    lin_d     = lin_q;
    wrap      = 1'b0;
    wr_o      = '0;
    waddr_o   = lin_q;
    if (cmd_i.step) begin
      unique case (cmd_i.ch)
        CH_RETURN: begin
        end
        CH_NEWLINE: begin
          wr_o.we    = 1'b1;
          wr_o.wchar = CH_BLANK;
          wrap       = 1'b1;
        end
        CH_BACKSPACE: begin
          if (!home) begin
            wr_o.we    = 1'b1;
            wr_o.wchar = CH_BLANK;
            waddr_o    = lin_q - LW'(1);
            lin_d      = lin_q - LW'(1);
            if (col_q == '0) begin
              col_d = CW'(COLUMNS - 1);
              row_d = row_q - RW'(1);
            end else begin
              col_d = col_q - CW'(1);
            end
          end
        end
        default: begin
          wr_o.we    = 1'b1;
          wr_o.wchar = cmd_i.ch;
          if (col_q == CW'(COLUMNS - 1)) begin
            wrap = 1'b1;
          end else begin
            col_d = col_q + CW'(1);
            lin_d = lin_q + LW'(1);
          end
        end
      endcase
      if (wrap) begin
        col_d = '0;
        if (row_q == RW'(ROWS - 1)) begin
          wr_o.scroll = 1'b1;
          lin_d       = LIN_BOTTOM;
        end else begin
          row_d = row_q + RW'(1);
          lin_d = LW'({1'b0, lin_q} + (LW+1)'(COLUMNS) - (LW+1)'(col_q));
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
      lin_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
      lin_q <= lin_d;
    end
  end

  assign lin_o = lin_q;

endmodule

/* rtl/text_console_char_writer_unit.sv */
// text console character writer top level with screen store and sequencer
//
// channel   dir  handshake     word
// in_i      in   valid/ready   kind, char_code, cell_index
// out_o     out  valid/ready   cursor_position, cell_char, cell_attr
// cfg       in   cfg_we_i      cfg_wdata_i (text attribute)
//
// an item is accepted (memory write or read issue) in the idle state, then its result is posted
// an item that scrolls first runs a scroll pass and a fill pass on the single screen write port:
// one copy per cell above the bottom row, one pipeline drain, one blank per bottom cell
// after reset a clearing pass zeroes all ROWS*COLUMNS cells
// a finished result waits in the output register while the next word is accepted
module text_console_char_writer_unit import tcw_pkg::*; #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ATTR_W-1:0] cfg_wdata_i,
  tcw_in_if.sink            in_i,
  tcw_out_if.source         out_o
);

  localparam int CELLS = COLUMNS * ROWS;
  localparam int LW    = $clog2(CELLS);
  localparam int XW    = (LW > IDX_W) ? LW : IDX_W;
  localparam logic [LW-1:0] LAST       = LW'(CELLS - 1);
  localparam logic [LW-1:0] LIN_BOTTOM = LW'((ROWS - 1) * COLUMNS);
  localparam int DW = CHAR_W + ATTR_W;

  typedef enum logic [2:0] {ST_CLEAR, ST_IDLE, ST_SCROLL, ST_FILL, ST_POST} state_e;

  state_e            state_q;
  logic [LW-1:0]     ptr_q;
  logic [LW-1:0]     cp_addr_q;
  logic              cp_pend_q;
  logic              rd_more_q;
  logic              is_read_q;
  logic              in_range_q;
  logic [ATTR_W-1:0] attr_q;
  logic              out_valid_q;
  logic [POS_W-1:0]  out_pos_q;
  logic [CHAR_W-1:0] out_char_q;
  logic [ATTR_W-1:0] out_attr_q;

  logic [DW-1:0]     mem [CELLS];
  logic [DW-1:0]     rd_q;
  logic              mem_we;
  logic [LW-1:0]     mem_waddr;
  logic [DW-1:0]     mem_wdata;
  logic              mem_re;
  logic [LW-1:0]     mem_raddr;

  logic              acc;
  logic              put_acc;
  logic              rd_acc;
  logic [XW-1:0]     idx_ext;
  logic              in_range;
  logic              post_go;

  cur_cmd_t          cur_cmd;
  cur_wr_t           cur_wr;
  logic [LW-1:0]     cur_waddr;
  logic [LW-1:0]     cur_lin;

  assign in_i.ready = (state_q == ST_IDLE);
  assign acc        = in_i.valid && in_i.ready;
  assign put_acc    = acc && (in_i.kind == KIND_PUT);
  assign rd_acc     = acc && (in_i.kind == KIND_READ);
  assign idx_ext    = XW'(in_i.cell_index);
  assign in_range   = {1'b0, idx_ext} < (XW+1)'(CELLS);
  assign post_go    = (state_q == ST_POST) && (!out_valid_q || out_o.ready);

  assign cur_cmd.step = put_acc;
  assign cur_cmd.ch   = in_i.char_code;

  tcw_cursor #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_cursor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (cur_cmd),
    .wr_o    (cur_wr),
    .waddr_o (cur_waddr),
    .lin_o   (cur_lin)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_q;
    mem_wdata = '0;
    mem_re    = 1'b0;
    mem_raddr = ptr_q;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we = 1'b1;
      end
      ST_IDLE: begin
        mem_we    = put_acc && cur_wr.we;
        mem_waddr = cur_waddr;
        mem_wdata = {attr_q, cur_wr.wchar};
        mem_re    = rd_acc;
        mem_raddr = idx_ext[LW-1:0];
      end
      ST_SCROLL: begin
        mem_we    = cp_pend_q;
        mem_waddr = cp_addr_q;
        mem_wdata = rd_q;
        mem_re    = rd_more_q;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = {attr_q, CH_BLANK};
      end
      ST_POST: begin
      end
      default: begin
      end
    endcase
  end

  // screen store, character in the low byte
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attr_q <= ATTR_RESET;
    end else if (cfg_we_i) begin
      attr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      ptr_q       <= '0;
      cp_addr_q   <= '0;
      cp_pend_q   <= 1'b0;
      rd_more_q   <= 1'b0;
      is_read_q   <= 1'b0;
      in_range_q  <= 1'b0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_char_q  <= '0;
      out_attr_q  <= '0;
    end else begin
      if (out_o.ready && !post_go) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          ptr_q <= ptr_q + LW'(1);
          if (ptr_q == LAST) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (acc) begin
            is_read_q  <= (in_i.kind == KIND_READ);
            in_range_q <= in_range;
            if (put_acc && cur_wr.scroll) begin
              state_q   <= ST_SCROLL;
              ptr_q     <= LW'(COLUMNS);
              rd_more_q <= 1'b1;
              cp_pend_q <= 1'b0;
            end else begin
              state_q <= ST_POST;
            end
          end
        end
        ST_SCROLL: begin
          cp_pend_q <= rd_more_q;
          cp_addr_q <= ptr_q - LW'(COLUMNS);
          if (rd_more_q) begin
            ptr_q     <= ptr_q + LW'(1);
            rd_more_q <= (ptr_q != LAST);
          end else begin
            state_q <= ST_FILL;
            ptr_q   <= LW'(CELLS - COLUMNS);
          end
        end
        ST_FILL: begin
          ptr_q <= ptr_q + LW'(1);
          if (ptr_q == LAST) begin
            state_q <= ST_POST;
          end
        end
        ST_POST: begin
          if (post_go) begin
            out_valid_q <= 1'b1;
            out_pos_q   <= POS_W'(cur_lin);
            if (is_read_q && in_range_q) begin
              out_char_q <= rd_q[CHAR_W-1:0];
              out_attr_q <= rd_q[DW-1:CHAR_W];
            end else begin
              out_char_q <= '0;
              out_attr_q <= '0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.cursor_position = out_pos_q;
  assign out_o.cell_char       = out_char_q;
  assign out_o.cell_attr       = out_attr_q;

  a_post_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_POST))
    else $error("result word raised outside post state");

  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (put_acc && cur_wr.scroll) |=> (cur_lin == LIN_BOTTOM) && (state_q == ST_SCROLL))
    else $error("scroll did not park cursor on bottom row");

  a_waddr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> ({1'b0, mem_waddr} < (LW+1)'(CELLS)))
    else $error("screen write beyond last cell");

endmodule
